// ===== sv/quaternion_attitude_pd_controller_macros.svh =====
// assertion macros shared by the attitude controller rtl
// no dependencies; included by files that carry concurrent checks
`ifndef QUATERNION_ATTITUDE_PD_CONTROLLER_MACROS_SVH
`define QUATERNION_ATTITUDE_PD_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define QAPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define QAPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qapd_pkg.sv =====
// types and constants of the quaternion attitude pd controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qapd_pkg;

	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 31;
	// squares, sum, root, numerator, divide, sign
	localparam int NORM_LAT    = 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;
	// products, sums, round, sign select, gains, torque round, clamp
	localparam int TOTAL_LAT   = NORM_LAT + 7;

	localparam logic [47:0] LIM_RESET = 48'h0100_0100_0100;

	typedef enum logic [1:0] {
		CFG_KP  = 2'd0,
		CFG_KD  = 2'd1,
		CFG_LIM = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] desired_qw;
		logic signed [15:0] desired_qx;
		logic signed [15:0] desired_qy;
		logic signed [15:0] desired_qz;
		logic signed [15:0] current_qw;
		logic signed [15:0] current_qx;
		logic signed [15:0] current_qy;
		logic signed [15:0] current_qz;
		logic [47:0] desired_rates;
		logic [47:0] measured_rates;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] torque_roll;
		logic signed [15:0] torque_pitch;
		logic signed [15:0] torque_yaw;
		logic saturated;
		logic valid_res;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	// unit quaternion, q.30
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} qn_t;

	// per-item data that rides along with the root extraction
	typedef struct packed {
		logic nz;
		logic [3:0] neg;
		logic [3:0][15:0] mag;
	} norm_side_t;

	typedef struct packed {
		logic signed [16:0] roll;
		logic signed [16:0] pitch;
		logic signed [16:0] yaw;
	} rate_diff_t;

endpackage

// ===== sv/qapd_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on qapd_pkg
`timescale 1ns / 1ps

module qapd_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic [63:0] in_val,
	input  qapd_pkg::norm_side_t in_side,
	output logic out_vld,
	output logic [31:0] out_root,
	output qapd_pkg::norm_side_t out_side
);
	import qapd_pkg::*;

	logic       vld_s  [1:SQRT_STAGES];
	logic [35:0] rem_s [1:SQRT_STAGES];
	logic [31:0] root_s [1:SQRT_STAGES];
	logic [63:0] rest_s [1:SQRT_STAGES];
	norm_side_t side_s [1:SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic       pv;
		logic [35:0] prem;
		logic [31:0] proot;
		logic [63:0] prest;
		norm_side_t pside;
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign pv = in_vld;
			assign prem = '0;
			assign proot = '0;
			assign prest = in_val;
			assign pside = in_side;
		end else begin : g_next
			assign pv = vld_s[k];
			assign prem = rem_s[k];
			assign proot = root_s[k];
			assign prest = rest_s[k];
			assign pside = side_s[k];
		end

		// bring down the next digit pair and try 4*root+1
		assign rem_sh = {prem[33:0], prest[63:62]};
		assign trial = {2'b00, proot, 2'b01};
		assign ge = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_sh - trial : rem_sh;
			root_s[k+1] <= {proot[30:0], ge};
			rest_s[k+1] <= {prest[61:0], 2'b00};
			side_s[k+1] <= pside;
		end
	end

	assign out_vld = vld_s[SQRT_STAGES];
	assign out_root = root_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];

endmodule

// ===== sv/qapd_div.sv =====
// pipelined restoring divider, 61-bit numerator by 32-bit divisor
// quotient known to fit 31 bits; depends on qapd_pkg
`timescale 1ns / 1ps

module qapd_div (
	input  logic clk,
	input  logic [60:0] num,
	input  logic [31:0] den,
	output logic [30:0] quo
);
	import qapd_pkg::*;

	logic [31:0] rem_s [1:DIV_STAGES];
	logic [60:0] num_s [1:DIV_STAGES];
	logic [31:0] den_s [1:DIV_STAGES];
	logic [30:0] quo_s [1:DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int B = DIV_STAGES - 1 - j;
		logic [31:0] prem;
		logic [60:0] pnum;
		logic [31:0] pden;
		logic [30:0] pquo;
		logic [32:0] rem2;
		logic [32:0] diff;
		logic        ge;

		if (j == 0) begin : g_first
			// upper numerator bits are already below the divisor
			assign prem = {2'b00, num[60:31]};
			assign pnum = num;
			assign pden = den;
			assign pquo = '0;
		end else begin : g_next
			assign prem = rem_s[j];
			assign pnum = num_s[j];
			assign pden = den_s[j];
			assign pquo = quo_s[j];
		end

		assign rem2 = {prem, pnum[B]};
		assign ge = rem2 >= {1'b0, pden};
		assign diff = rem2 - {1'b0, pden};

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? diff[31:0] : rem2[31:0];
			num_s[j+1] <= pnum;
			den_s[j+1] <= pden;
			quo_s[j+1] <= {pquo[29:0], ge};
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

// ===== sv/qapd_norm.sv =====
// quaternion normalizer: squares, sum, root, rounded divide per component
// depends on qapd_pkg, qapd_sqrt, qapd_div
`timescale 1ns / 1ps

module qapd_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  qapd_pkg::quat_t q,
	output logic out_vld,
	output logic out_nz,
	output qapd_pkg::qn_t n
);
	import qapd_pkg::*;

	typedef struct packed {
		logic vld;
		logic nz;
		logic [3:0] neg;
	} div_side_t;

	logic signed [15:0] comp [4];
	logic [15:0] mag [4];

	logic        vld_s1;
	logic [3:0]  neg_s1;
	logic [15:0] mag_s1 [4];
	logic [31:0] sq_s1 [4];

	logic        vld_s2;
	logic [32:0] ss_s2;
	norm_side_t  side_s2;

	logic        root_vld;
	logic [31:0] root;
	norm_side_t  root_side;

	logic        vld_s35;
	logic [31:0] r_s35;
	norm_side_t  side_s35;
	logic [60:0] num_s35 [4];

	logic [30:0] quo [4];
	div_side_t   dside_q [1:DIV_STAGES];

	logic        vld_s67;
	logic        nz_s67;
	logic signed [31:0] n_s67 [4];

	assign comp[0] = q.w;
	assign comp[1] = q.x;
	assign comp[2] = q.y;
	assign comp[3] = q.z;

	for (genvar i = 0; i < 4; i++) begin : g_mag
		assign mag[i] = comp[i][15] ? 16'(-comp[i]) : 16'(comp[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s35 <= 1'b0;
			vld_s67 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s35 <= root_vld;
			vld_s67 <= dside_q[DIV_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			neg_s1[i] <= comp[i][15];
			mag_s1[i] <= mag[i];
			sq_s1[i] <= mag[i] * mag[i];
		end
		ss_s2 <= 33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2]) + 33'(sq_s1[3]);
		side_s2.nz <= (sq_s1[0] | sq_s1[1] | sq_s1[2] | sq_s1[3]) != '0;
		side_s2.neg <= neg_s1;
		for (int i = 0; i < 4; i++) begin
			side_s2.mag[i] <= mag_s1[i];
		end
	end

	// root of ss * 2^30, the norm in q.15
	qapd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_val  ({1'b0, ss_s2, 30'd0}),
		.in_side (side_s2),
		.out_vld (root_vld),
		.out_root(root),
		.out_side(root_side)
	);

	// numerator |c| * 2^45 plus half the divisor for round half up
	always_ff @(posedge clk) begin
		r_s35 <= root;
		side_s35 <= root_side;
		for (int i = 0; i < 4; i++) begin
			num_s35[i] <= {root_side.mag[i], 45'd0} + 61'(root[31:1]);
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		qapd_div u_div (
			.clk(clk),
			.num(num_s35[i]),
			.den(r_s35),
			.quo(quo[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++) begin
				dside_q[k] <= '0;
			end
		end else begin
			dside_q[1] <= '{vld: vld_s35, nz: side_s35.nz, neg: side_s35.neg};
			for (int k = 2; k <= DIV_STAGES; k++) begin
				dside_q[k] <= dside_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		nz_s67 <= dside_q[DIV_STAGES].nz;
		for (int i = 0; i < 4; i++) begin
			n_s67[i] <= dside_q[DIV_STAGES].neg[i] ? -$signed({1'b0, quo[i]})
				: $signed({1'b0, quo[i]});
		end
	end

	assign out_vld = vld_s67;
	assign out_nz = nz_s67;
	assign n.w = n_s67[0];
	assign n.x = n_s67[1];
	assign n.y = n_s67[2];
	assign n.z = n_s67[3];

endmodule

// ===== sv/quaternion_attitude_pd_controller.sv =====
// quaternion attitude pd controller top level: error quaternion and torque
// depends on qapd_pkg, qapd_norm and the assertion macro header
//
// usage
//  input: drive item and raise start; a word is taken at every clock edge
//  where start is high and busy is low. busy stays low, so a new word can
//  enter on every cycle.
//  output: each word yields one result on result, marked by done for one
//  cycle. the pipeline never waits, so results cannot be held off; collect
//  them as done pulses.
//  throughput is one word per cycle; latency is set by the 32-stage root
//  and 31-stage divide pipelines of the normalizers plus 11 arithmetic
//  stages.
//  configuration: write gains and limits through cfg_valid/cfg_index/
//  cfg_data; cfg_ready is always high. write only while no word is in flight.
//  reset: arst_n clears all valid bits and loads gains of zero and limits
//  of 1.0 on every axis; no result appears until a word is taken.
`timescale 1ns / 1ps

module quaternion_attitude_pd_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  qapd_pkg::in_word_t item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [47:0] cfg_data,
	output logic done,
	output qapd_pkg::out_word_t result
);
	import qapd_pkg::*;
	`include "quaternion_attitude_pd_controller_macros.svh"

	localparam int DIFF_DEPTH = NORM_LAT + 4;

	logic [47:0] kp_q;
	logic [47:0] kd_q;
	logic [47:0] lim_q;

	logic accept;
	quat_t qd_in;
	quat_t qc_in;
	rate_diff_t diff_in;
	rate_diff_t diff_pipe_q [0:DIFF_DEPTH-1];

	logic nd_vld;
	logic nd_nz;
	qn_t  nd;
	logic nc_vld;
	logic nc_nz;
	qn_t  nc;
	logic signed [31:0] cv [4];
	logic signed [31:0] dv [4];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic signed [63:0] prod_s1 [4][4];
	logic signed [63:0] esum_s2 [4];
	logic signed [34:0] err_s3 [4];
	logic signed [34:0] vec_s4 [3];
	logic signed [51:0] pk_s5 [3];
	logic signed [33:0] dk_s5 [3];
	logic signed [27:0] tq_s6 [3];
	out_word_t res_s7;

	logic signed [16:0] diff_t [3];
	logic signed [34:0] vsel [3];
	logic signed [15:0] tq_out [3];
	logic [2:0] sat_ax;

	function automatic logic signed [34:0] rnd_err(input logic signed [63:0] s);
		logic [63:0] mag;
		logic [63:0] rm;
		logic [34:0] m35;
		mag = s[63] ? 64'(-s) : 64'(s);
		rm = (mag + (64'd1 << 29)) >> 30;
		m35 = rm[34:0];
		return s[63] ? -$signed(m35) : $signed(m35);
	endfunction

	function automatic logic signed [27:0] rnd_tq(input logic signed [55:0] s);
		logic [55:0] mag;
		logic [55:0] rm;
		logic [27:0] m28;
		mag = s[55] ? 56'(-s) : 56'(s);
		rm = (mag + (56'd1 << 29)) >> 30;
		m28 = rm[27:0];
		return s[55] ? -$signed(m28) : $signed(m28);
	endfunction

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			kd_q <= '0;
			lim_q <= LIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KP:  kp_q <= cfg_data;
				CFG_KD:  kd_q <= cfg_data;
				CFG_LIM: lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign qd_in = '{w: item.desired_qw, x: item.desired_qx,
		y: item.desired_qy, z: item.desired_qz};
	assign qc_in = '{w: item.current_qw, x: item.current_qx,
		y: item.current_qy, z: item.current_qz};

	assign diff_in.roll = 17'($signed(item.desired_rates[15:0]))
		- 17'($signed(item.measured_rates[15:0]));
	assign diff_in.pitch = 17'($signed(item.desired_rates[31:16]))
		- 17'($signed(item.measured_rates[31:16]));
	assign diff_in.yaw = 17'($signed(item.desired_rates[47:32]))
		- 17'($signed(item.measured_rates[47:32]));

	// rate difference waits alongside the normalizers and error stages
	always_ff @(posedge clk) begin
		diff_pipe_q[0] <= diff_in;
		for (int k = 1; k < DIFF_DEPTH; k++) begin
			diff_pipe_q[k] <= diff_pipe_q[k-1];
		end
	end

	qapd_norm u_norm_des (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.q      (qd_in),
		.out_vld(nd_vld),
		.out_nz (nd_nz),
		.n      (nd)
	);

	qapd_norm u_norm_cur (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.q      (qc_in),
		.out_vld(nc_vld),
		.out_nz (nc_nz),
		.n      (nc)
	);

	assign cv[0] = nc.w;
	assign cv[1] = nc.x;
	assign cv[2] = nc.y;
	assign cv[3] = nc.z;
	assign dv[0] = nd.w;
	assign dv[1] = nd.x;
	assign dv[2] = nd.y;
	assign dv[3] = nd.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= nd_vld & nc_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// conj(current) * desired: all sixteen products, exact in q.60
	always_ff @(posedge clk) begin
		ok_s1 <= nd_nz & nc_nz;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[i][j] <= 64'(cv[i]) * 64'(dv[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1;
		esum_s2[0] <= prod_s1[0][0] + prod_s1[1][1] + prod_s1[2][2] + prod_s1[3][3];
		esum_s2[1] <= prod_s1[0][1] - prod_s1[1][0] - (prod_s1[2][3] - prod_s1[3][2]);
		esum_s2[2] <= prod_s1[0][2] - prod_s1[2][0] - (prod_s1[3][1] - prod_s1[1][3]);
		esum_s2[3] <= prod_s1[0][3] - prod_s1[3][0] - (prod_s1[1][2] - prod_s1[2][1]);
	end

	always_ff @(posedge clk) begin
		ok_s3 <= ok_s2;
		for (int i = 0; i < 4; i++) begin
			err_s3[i] <= rnd_err(esum_s2[i]);
		end
	end

	// shortest path; at w == 0 the largest vector part (lowest axis on ties)
	// picks the sign
	always_comb begin
		logic [34:0] ab [3];
		logic [34:0] best;
		logic dneg;
		logic flip;
		for (int i = 0; i < 3; i++) begin
			ab[i] = err_s3[i+1][34] ? 35'(-err_s3[i+1]) : 35'(err_s3[i+1]);
		end
		best = ab[0];
		dneg = err_s3[1][34];
		if (ab[1] > best) begin
			best = ab[1];
			dneg = err_s3[2][34];
		end
		if (ab[2] > best) begin
			dneg = err_s3[3][34];
		end
		flip = err_s3[0][34] | ((err_s3[0] == '0) & dneg);
		for (int i = 0; i < 3; i++) begin
			vsel[i] = flip ? -err_s3[i+1] : err_s3[i+1];
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= ok_s3;
		for (int i = 0; i < 3; i++) begin
			vec_s4[i] <= vsel[i];
		end
	end

	assign diff_t[0] = diff_pipe_q[DIFF_DEPTH-1].roll;
	assign diff_t[1] = diff_pipe_q[DIFF_DEPTH-1].pitch;
	assign diff_t[2] = diff_pipe_q[DIFF_DEPTH-1].yaw;

	always_ff @(posedge clk) begin
		ok_s5 <= ok_s4;
		for (int i = 0; i < 3; i++) begin
			pk_s5[i] <= $signed({1'b0, kp_q[16*i +: 16]}) * vec_s4[i];
			dk_s5[i] <= $signed({1'b0, kd_q[16*i +: 16]}) * diff_t[i];
		end
	end

	// q.38 sum rounded to q8.8
	always_ff @(posedge clk) begin
		ok_s6 <= ok_s5;
		for (int i = 0; i < 3; i++) begin
			tq_s6[i] <= rnd_tq((56'(pk_s5[i]) <<< 1) + (56'(dk_s5[i]) <<< 19));
		end
	end

	always_comb begin
		logic signed [27:0] lim;
		logic signed [27:0] o;
		for (int i = 0; i < 3; i++) begin
			lim = $signed({12'd0, lim_q[16*i +: 16]});
			o = tq_s6[i];
			if (o > lim) o = lim;
			if (o < -lim) o = -lim;
			if (o > 28'sd32767) o = 28'sd32767;
			if (o < -28'sd32768) o = -28'sd32768;
			sat_ax[i] = o != tq_s6[i];
			tq_out[i] = o[15:0];
		end
	end

	always_ff @(posedge clk) begin
		res_s7.torque_roll <= ok_s6 ? tq_out[0] : '0;
		res_s7.torque_pitch <= ok_s6 ? tq_out[1] : '0;
		res_s7.torque_yaw <= ok_s6 ? tq_out[2] : '0;
		res_s7.saturated <= ok_s6 & (|sat_ax);
		res_s7.valid_res <= ok_s6;
	end

	assign done = vld_s7;
	assign result = res_s7;

	`QAPD_ASSERT_IMPLIES(a_latency, clk, arst_n, done, $past(start, TOTAL_LAT), "result without word")
	`QAPD_ASSERT_IMPLIES(a_zero_quat, clk, arst_n, done && !result.valid_res, result.torque_roll == 16'sd0 && result.torque_pitch == 16'sd0 && result.torque_yaw == 16'sd0 && !result.saturated, "invalid result not zero")
	`QAPD_ASSERT_IMPLIES(a_sat_valid, clk, arst_n, done && result.saturated, result.valid_res, "saturation on invalid result")
	`QAPD_ASSERT_NEXT(a_lim_write, clk, arst_n, cfg_valid && cfg_ready && cfg_index == CFG_LIM, lim_q == $past(cfg_data), "limit write lost")

endmodule

// ===== tb/sv/tb_quaternion_attitude_pd_controller.sv =====
// self-checking testbench for the quaternion attitude pd controller
// depends on qapd_pkg and the controller rtl; predicts each result in place
`timescale 1ns / 1ps

module tb_quaternion_attitude_pd_controller;
	import qapd_pkg::*;

	localparam int MAX_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic done;
	out_word_t result;

	logic [47:0] kp_gains = '0;
	logic [47:0] kd_gains = '0;
	logic [47:0] lim_gains = LIM_RESET;

	in_word_t pending_words[$];
	out_word_t expected_torques[$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	int cycles = 0;
	bit feed_en = 1'b0;
	bit quiet = 1'b0;

	quaternion_attitude_pd_controller i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b, x;
		x = v;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint round_away(input longint v, input int s);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// four q1.14 components to q.30 unit components
	function automatic bit unit_quat(input longint q[4], output longint n[4]);
		longint unsigned ss, r, m;
		ss = 0;
		for (int i = 0; i < 4; i++) ss += q[i] * q[i];
		for (int i = 0; i < 4; i++) n[i] = 0;
		if (ss == 0) return 1'b0;
		r = isqrt(ss << 30);
		for (int i = 0; i < 4; i++) begin
			m = (q[i] < 0) ? -q[i] : q[i];
			m = ((m << 45) + (r >> 1)) / r;
			n[i] = (q[i] < 0) ? -longint'(m) : longint'(m);
		end
		return 1'b1;
	endfunction

	function automatic out_word_t control_torque(input in_word_t w);
		out_word_t o;
		longint dq[4], cq[4], d[4], c[4], e[4], v[3];
		longint best, a, kp, kd, lim, diff, t, clip;
		int dom;
		bit neg, sat;
		o = '0;
		dq = '{w.desired_qw, w.desired_qx, w.desired_qy, w.desired_qz};
		cq = '{w.current_qw, w.current_qx, w.current_qy, w.current_qz};
		if (!unit_quat(dq, d)) return o;
		if (!unit_quat(cq, c)) return o;
		e[0] = round_away(c[0]*d[0] + c[1]*d[1] + c[2]*d[2] + c[3]*d[3], 30);
		e[1] = round_away(c[0]*d[1] - d[0]*c[1] - (c[2]*d[3] - c[3]*d[2]), 30);
		e[2] = round_away(c[0]*d[2] - d[0]*c[2] - (c[3]*d[1] - c[1]*d[3]), 30);
		e[3] = round_away(c[0]*d[3] - d[0]*c[3] - (c[1]*d[2] - c[2]*d[1]), 30);
		neg = e[0] < 0;
		// half turn: dominant vector axis decides, lowest axis on a tie
		if (e[0] == 0) begin
			best = -1;
			dom = 0;
			for (int i = 0; i < 3; i++) begin
				a = (e[1+i] < 0) ? -e[1+i] : e[1+i];
				if (a > best) begin
					best = a;
					dom = i;
				end
			end
			neg = e[1+dom] < 0;
		end
		for (int i = 0; i < 3; i++) v[i] = neg ? -e[1+i] : e[1+i];
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			kp = kp_gains[16*i +: 16];
			kd = kd_gains[16*i +: 16];
			lim = lim_gains[16*i +: 16];
			diff = longint'($signed(w.desired_rates[16*i +: 16]))
				- longint'($signed(w.measured_rates[16*i +: 16]));
			t = round_away(kp * v[i] * 2 + kd * diff * (longint'(1) << 19), 30);
			clip = t;
			if (clip > lim) clip = lim;
			if (clip < -lim) clip = -lim;
			if (clip > 32767) clip = 32767;
			if (clip < -32768) clip = -32768;
			if (clip != t) sat = 1'b1;
			if (i == 0) o.torque_roll = clip[15:0];
			else if (i == 1) o.torque_pitch = clip[15:0];
			else o.torque_yaw = clip[15:0];
		end
		o.saturated = sat;
		o.valid_res = 1'b1;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		$display("mismatch at word %0d: %s got %h want %h", checked, what, got, want);
	endtask

	// driver: takes words from the pending queue at falling edges
	always @(negedge clk) begin
		if (start && !busy) begin
			expected_torques.push_back(control_torque(item));
			sent++;
		end
		if (feed_en && pending_words.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
			item <= pending_words.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && done) begin
			if (expected_torques.size() == 0) begin
				report_mismatch("unexpected result", 16'h0, 16'h0);
			end else begin
				out_word_t x;
				x = expected_torques.pop_front();
				if (result.torque_roll !== x.torque_roll)
					report_mismatch("torque_roll", result.torque_roll, x.torque_roll);
				if (result.torque_pitch !== x.torque_pitch)
					report_mismatch("torque_pitch", result.torque_pitch, x.torque_pitch);
				if (result.torque_yaw !== x.torque_yaw)
					report_mismatch("torque_yaw", result.torque_yaw, x.torque_yaw);
				if (result.saturated !== x.saturated)
					report_mismatch("saturated", result.saturated, x.saturated);
				if (result.valid_res !== x.valid_res)
					report_mismatch("valid_res", result.valid_res, x.valid_res);
				checked++;
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_KP: kp_gains = data;
			CFG_KD: kd_gains = data;
			default: lim_gains = data;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_pipe();
		while (pending_words.size() != 0 || start || expected_torques.size() != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 8) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 2000)) - 1000);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.desired_qw = rand_comp();
		w.desired_qx = rand_comp();
		w.desired_qy = rand_comp();
		w.desired_qz = rand_comp();
		if ($urandom_range(3) == 0) begin
			// nearby current attitude, small error
			w.current_qw = w.desired_qw + 16'($urandom_range(0, 64)) - 16'd32;
			w.current_qx = w.desired_qx + 16'($urandom_range(0, 64)) - 16'd32;
			w.current_qy = w.desired_qy;
			w.current_qz = w.desired_qz;
		end else begin
			w.current_qw = rand_comp();
			w.current_qx = rand_comp();
			w.current_qy = rand_comp();
			w.current_qz = rand_comp();
		end
		if ($urandom_range(15) == 0) w.current_qw = '0;
		if ($urandom_range(15) == 0) {w.desired_qw, w.desired_qx, w.desired_qy, w.desired_qz} = '0;
		w.desired_rates = rand48();
		w.measured_rates = rand48();
		return w;
	endfunction

	function automatic in_word_t make_word(input logic [15:0] dw, dx, dy, dz, cw, cx, cy, cz,
			input logic [47:0] dr, mr);
		in_word_t w;
		w = {dw, dx, dy, dz, cw, cx, cy, cz, dr, mr};
		return w;
	endfunction

	initial begin
		logic [47:0] settings[3][5];
		settings[0] = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0100_0200_0080, 48'h0, 48'h0};
		settings[1] = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0040_0100_0300, 48'h0, 48'h0};
		settings[2] = '{48'h7FFF_0001_0100, 48'hFFFF_FFFF_FFFF, 48'h0400_0100_0200,
			48'h0, 48'h0100_0000_0100};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset limits
		write_reg(CFG_KP, 48'h0100_0100_0100);
		write_reg(CFG_KD, 48'h0080_0080_0080);
		pending_words.push_back(make_word(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 0, 0, 0, 16'h4000, 0, 0, 0, 48'h1234, 0));
		pending_words.push_back(make_word(16'h4000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 16'h4000, 0, 0, 16'h4000, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 16'hC000, 0, 0, 16'h4000, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 0, 16'hC000, 0, 16'h4000, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(0, 16'hC000, 16'h4000, 0, 16'h4000, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(16'hC000, 0, 0, 0, 16'h4000, 16'h1000, 0, 0, 0, 0));
		pending_words.push_back(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000));
		pending_words.push_back(make_word(16'h0001, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0,
			48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF));
		pending_words.push_back(make_word(16'h4000, 16'h1000, 16'h2000, 16'h3000,
			16'h3000, 16'hF000, 16'h0800, 16'hE000, 48'h0100_FF00_0010, 48'h0001_0002_FFFE));
		feed_en = 1'b1;
		drain_pipe();

		// random phases over several gain and limit settings, extremes included
		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_KP, p == 1 ? settings[0][1] : (p == 0 ? 48'h0 : rand48()));
			write_reg(CFG_KD, p == 1 ? settings[1][1] : (p == 3 ? 48'h0 : rand48()));
			write_reg(CFG_LIM, p == 1 ? settings[2][1] : settings[2][p == 0 ? 4 : p % 3]);
			quiet = (p == 2);
			for (int i = 0; i < 400; i++) pending_words.push_back(rand_word());
			// sender pauses mid-phase until the pipe is empty
			while (pending_words.size() > 200) @(posedge clk);
			feed_en = 1'b0;
			while (start || expected_torques.size() != 0) @(posedge clk);
			feed_en = 1'b1;
			drain_pipe();
		end

		$display("sent %0d words, checked %0d results over six gain/limit settings",
			sent, checked);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
